FILE: sv/dssm_pkg.sv
// ----------------------------------------------------------------------------
// Dual stack shared memory package
// Sizes, request and status codes, beat payload types and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package dssm_pkg;

  localparam int DEPTH  = 64;
  localparam int WORD_W = 32;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic [1:0] REQ_PUSH    = 2'd0;
  localparam logic [1:0] REQ_POP     = 2'd1;
  localparam logic [1:0] REQ_PEEK    = 2'd2;
  localparam logic [1:0] REQ_DISPLAY = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  typedef struct packed {
    logic [1:0]               req_type;
    logic                     stack_sel;
    logic signed [WORD_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] read_value;
    logic                     last_of_run;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic direct;
    logic issue;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic             needs_read;
    logic             walk_more;
    logic             full;
    logic [CNT_W-1:0] lower_cnt;
    logic [CNT_W-1:0] upper_cnt;
  } dp_stat_t;

endpackage

FILE: sv/dssm_dp.sv
// ----------------------------------------------------------------------------
// Dual stack shared memory datapath
// Holds the shared word store, both stack counts, the walk pointer, the
// registered read stage and the output register.
// ----------------------------------------------------------------------------
module dssm_dp
  import dssm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  ctrl_cmd_t  cmd,
  output dp_stat_t   stat,
  output out_item_t  out_data
);

  logic [WORD_W-1:0] mem [DEPTH];

  logic [CNT_W-1:0]  lower_cnt_r;
  logic [CNT_W-1:0]  upper_cnt_r;
  logic              sel_r;
  logic [CNT_W-1:0]  idx_r;
  logic [CNT_W-1:0]  end_r;
  logic [WORD_W-1:0] rd_data_r;
  logic              rd_last_r;
  out_item_t         out_r;

  logic [CNT_W-1:0]  sel_cnt;
  logic [CNT_W:0]    total;
  logic              full;
  logic              is_push;
  logic              is_pop;
  logic              nonempty;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  out_item_t         direct_res;

  always_comb begin
    sel_cnt  = in_data.stack_sel ? upper_cnt_r : lower_cnt_r;
    total    = {1'b0, lower_cnt_r} + {1'b0, upper_cnt_r};
    full     = total >= (CNT_W + 1)'(DEPTH);
    is_push  = in_data.req_type == REQ_PUSH;
    is_pop   = in_data.req_type == REQ_POP;
    nonempty = sel_cnt != '0;
    wr_addr  = in_data.stack_sel ? ADDR_W'(DEPTH - 1) - sel_cnt[ADDR_W-1:0]
                                 : sel_cnt[ADDR_W-1:0];
    rd_addr  = sel_r ? ADDR_W'(DEPTH - 1) - idx_r[ADDR_W-1:0] : idx_r[ADDR_W-1:0];

    direct_res.status      = is_push ? (full ? ST_OVERFLOW : ST_OK) : ST_EMPTY;
    direct_res.read_value  = '0;
    direct_res.last_of_run = 1'b1;

    stat.needs_read = !is_push && nonempty;
    stat.walk_more  = idx_r != end_r;
    stat.full       = full;
    stat.lower_cnt  = lower_cnt_r;
    stat.upper_cnt  = upper_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && is_push && !full) begin
      mem[wr_addr] <= in_data.push_value;
    end
    if (cmd.issue) begin
      rd_data_r <= mem[rd_addr];
      rd_last_r <= (idx_r + CNT_W'(1)) == end_r;
    end
    if (cmd.direct) begin
      out_r <= direct_res;
    end else if (cmd.load_out) begin
      out_r.status      <= ST_OK;
      out_r.read_value  <= rd_data_r;
      out_r.last_of_run <= rd_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_cnt_r <= '0;
      upper_cnt_r <= '0;
      sel_r       <= 1'b0;
      idx_r       <= '0;
      end_r       <= '0;
    end else begin
      if (cmd.accept) begin
        if (is_push && !full) begin
          if (in_data.stack_sel) begin
            upper_cnt_r <= upper_cnt_r + CNT_W'(1);
          end else begin
            lower_cnt_r <= lower_cnt_r + CNT_W'(1);
          end
        end else if (is_pop && nonempty) begin
          if (in_data.stack_sel) begin
            upper_cnt_r <= upper_cnt_r - CNT_W'(1);
          end else begin
            lower_cnt_r <= lower_cnt_r - CNT_W'(1);
          end
        end
        if (!is_push && nonempty) begin
          sel_r <= in_data.stack_sel;
          idx_r <= (in_data.req_type == REQ_DISPLAY) ? '0 : sel_cnt - CNT_W'(1);
          end_r <= sel_cnt;
        end
      end else if (cmd.issue) begin
        idx_r <= idx_r + CNT_W'(1);
      end
    end
  end

  assign out_data = out_r;

endmodule

FILE: sv/dssm_ctrl.sv
// ----------------------------------------------------------------------------
// Dual stack shared memory controller
// Sequences request acceptance, store reads and output beats, and keeps the
// valid flags of the read stage and the output register.
// ----------------------------------------------------------------------------
module dssm_ctrl
  import dssm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  cmd
);

  typedef enum logic {S_IDLE, S_BUSY} state_t;

  state_t state_r;
  state_t state_nxt;
  logic   pend_r;
  logic   pend_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  always_comb begin
    out_free     = !out_valid_r || out_ready;
    in_ready     = (state_r == S_IDLE) && out_free;
    cmd.accept   = in_valid && in_ready;
    cmd.direct   = cmd.accept && !stat.needs_read;
    cmd.load_out = (state_r == S_BUSY) && pend_r && out_free;
    cmd.issue    = (state_r == S_BUSY) && stat.walk_more && (!pend_r || cmd.load_out);

    pend_nxt      = cmd.issue || (pend_r && !cmd.load_out);
    out_valid_nxt = cmd.direct || cmd.load_out || (out_valid_r && !out_ready);

    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.accept && stat.needs_read) begin
          state_nxt = S_BUSY;
        end
      end
      S_BUSY: begin
        if (!cmd.issue && !stat.walk_more && (!pend_r || cmd.load_out)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: sv/dual_stack_shared_memory.sv
// ----------------------------------------------------------------------------
// Dual stack shared memory
// Push and any request on an empty stack give their beat the cycle after
// acceptance; pop and peek pass it through the walk pointer, the read stage
// and the output register. Push takes one request per cycle and display gives
// one word per cycle, bound by the single registered read port, while output
// is not stalled; reads block new requests. Reset empties both stacks at once.
// ----------------------------------------------------------------------------
module dual_stack_shared_memory
  import dssm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  dssm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  dssm_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, stat.lower_cnt} + {1'b0, stat.upper_cnt}) <= (CNT_W + 1)'(DEPTH))
    else $error("Stack counts exceed the store depth.");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && in_data.req_type == REQ_PUSH && !stat.full) |=>
    ({1'b0, stat.lower_cnt} + {1'b0, stat.upper_cnt}) ==
    ($past({1'b0, stat.lower_cnt} + {1'b0, stat.upper_cnt}) + (CNT_W + 1)'(1)))
    else $error("Accepted push did not grow the stacks by one word.");

  a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |-> out_data.last_of_run)
    else $error("Error beat is not flagged as the last of its run.");

endmodule

FILE: tb/dual_stack_shared_memory_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual stack shared memory testbench
// Drives push, pop, peek and display requests on both stacks and keeps its
// own copy of the shared word store and both stack depths. Every result beat
// is checked in order against the beats that copy predicts. Runs directed
// corner cases, a fill to overflow and random traffic under several
// idling and back-pressure mixes.
// ----------------------------------------------------------------------------
module dual_stack_shared_memory_test;
  import dssm_pkg::*;

  localparam logic LOWER_STACK = 1'b0;
  localparam logic UPPER_STACK = 1'b1;
  localparam int   QUIET_LIMIT = 4000;
  localparam int   PRINT_LIMIT = 40;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  logic [WORD_W-1:0] stack_words [DEPTH];
  int                lower_depth = 0;
  int                upper_depth = 0;
  out_item_t         owed_beats [$];
  int                mismatch_count = 0;
  int                quiet_cycles = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  bit                filling_mode = 1'b1;

  dual_stack_shared_memory dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic int word_addr(input logic upper, input int index);
    return upper ? DEPTH - 1 - index : index;
  endfunction

  function automatic void predict_beats(input in_item_t req);
    int        depth_now;
    out_item_t beat;
    depth_now = req.stack_sel ? upper_depth : lower_depth;
    beat.status = ST_OK;
    beat.read_value = '0;
    beat.last_of_run = 1'b1;
    case (req.req_type)
      REQ_PUSH: begin
        if (lower_depth + upper_depth >= DEPTH) begin
          beat.status = ST_OVERFLOW;
        end else begin
          stack_words[word_addr(req.stack_sel, depth_now)] = req.push_value;
          if (req.stack_sel) upper_depth++;
          else lower_depth++;
        end
        owed_beats.push_back(beat);
      end
      REQ_POP, REQ_PEEK: begin
        if (depth_now == 0) begin
          beat.status = ST_EMPTY;
        end else begin
          beat.read_value = stack_words[word_addr(req.stack_sel, depth_now - 1)];
          if (req.req_type == REQ_POP) begin
            if (req.stack_sel) upper_depth--;
            else lower_depth--;
          end
        end
        owed_beats.push_back(beat);
      end
      REQ_DISPLAY: begin
        if (depth_now == 0) begin
          beat.status = ST_EMPTY;
          owed_beats.push_back(beat);
        end else begin
          for (int i = 0; i < depth_now; i++) begin
            beat.read_value = stack_words[word_addr(req.stack_sel, i)];
            beat.last_of_run = (i == depth_now - 1);
            owed_beats.push_back(beat);
          end
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("%0t ERROR: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) predict_beats(in_data);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat status=%0d value=%h last=%0b",
                                  out_data.status, out_data.read_value,
                                  out_data.last_of_run));
      end else begin
        want = owed_beats.pop_front();
        if (out_data.status !== want.status ||
            out_data.read_value !== want.read_value ||
            out_data.last_of_run !== want.last_of_run)
          report_mismatch($sformatf(
            "beat got status=%0d value=%h last=%0b, expected %0d %h %0b",
            out_data.status, out_data.read_value, out_data.last_of_run,
            want.status, want.read_value, want.last_of_run));
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  function automatic in_item_t make_request(input logic [1:0] kind, input logic sel,
                                            input logic [WORD_W-1:0] value);
    in_item_t req;
    req.req_type = kind;
    req.stack_sel = sel;
    req.push_value = value;
    return req;
  endfunction

  // Called just after a falling edge; returns just after the falling edge that
  // follows acceptance, with valid still high so that back-to-back beats need
  // only one assignment per edge.
  task automatic send_request(input in_item_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic test_empty_requests();
    send_request(make_request(REQ_POP, LOWER_STACK, $urandom));
    send_request(make_request(REQ_POP, UPPER_STACK, $urandom));
    send_request(make_request(REQ_PEEK, LOWER_STACK, $urandom));
    send_request(make_request(REQ_PEEK, UPPER_STACK, $urandom));
    send_request(make_request(REQ_DISPLAY, LOWER_STACK, $urandom));
    send_request(make_request(REQ_DISPLAY, UPPER_STACK, $urandom));
  endtask

  task automatic test_extreme_values();
    send_request(make_request(REQ_PUSH, LOWER_STACK, 32'h7fff_ffff));
    send_request(make_request(REQ_PUSH, UPPER_STACK, 32'h8000_0000));
    send_request(make_request(REQ_PUSH, LOWER_STACK, 32'h0000_0000));
    send_request(make_request(REQ_PUSH, UPPER_STACK, 32'hffff_ffff));
    send_request(make_request(REQ_PUSH, LOWER_STACK, 32'h5555_5555));
    send_request(make_request(REQ_PUSH, UPPER_STACK, 32'haaaa_aaaa));
    send_request(make_request(REQ_PEEK, LOWER_STACK, $urandom));
    send_request(make_request(REQ_PEEK, UPPER_STACK, $urandom));
    send_request(make_request(REQ_DISPLAY, LOWER_STACK, $urandom));
    send_request(make_request(REQ_DISPLAY, UPPER_STACK, $urandom));
    repeat (3) begin
      send_request(make_request(REQ_POP, LOWER_STACK, $urandom));
      send_request(make_request(REQ_POP, UPPER_STACK, $urandom));
    end
    send_request(make_request(REQ_POP, LOWER_STACK, $urandom));
  endtask

  task automatic test_overflow();
    while (lower_depth + upper_depth < DEPTH)
      send_request(make_request(REQ_PUSH, 1'($urandom_range(1)), $urandom));
    send_request(make_request(REQ_PUSH, LOWER_STACK, $urandom));
    send_request(make_request(REQ_PUSH, UPPER_STACK, $urandom));
    send_request(make_request(REQ_DISPLAY, LOWER_STACK, $urandom));
    send_request(make_request(REQ_DISPLAY, UPPER_STACK, $urandom));
    send_request(make_request(REQ_PEEK, LOWER_STACK, $urandom));
    send_request(make_request(REQ_PEEK, UPPER_STACK, $urandom));
    filling_mode = 1'b0;
  endtask

  // Traffic swings between filling and draining so that the combined depth of
  // both stacks passes between at most one word and full.
  task automatic test_random_traffic(input int count, input int idle_pct,
                                     input int stall_pct);
    in_item_t req;
    int       pick;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      if (lower_depth + upper_depth >= DEPTH) filling_mode = 1'b0;
      else if (lower_depth + upper_depth <= 1) filling_mode = 1'b1;
      pick = $urandom_range(99);
      req.stack_sel = 1'($urandom_range(1));
      req.push_value = $urandom;
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0: req.push_value = 32'h8000_0000;
          1: req.push_value = 32'h7fff_ffff;
          2: req.push_value = 32'h0000_0000;
          default: req.push_value = 32'hffff_ffff;
        endcase
      end
      if (filling_mode)
        req.req_type = (pick < 80) ? REQ_PUSH : (pick < 90) ? REQ_POP :
                       (pick < 95) ? REQ_PEEK : REQ_DISPLAY;
      else
        req.req_type = (pick < 10) ? REQ_PUSH : (pick < 85) ? REQ_POP :
                       (pick < 93) ? REQ_PEEK : REQ_DISPLAY;
      send_request(req);
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_empty_requests();
    test_extreme_values();
    test_overflow();
    test_random_traffic(30, 0, 0);
    test_random_traffic(30, 86, 0);
    test_random_traffic(30, 0, 86);
    test_random_traffic(30, 34, 34);
    in_valid <= 1'b0;
    while (owed_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: dual_stack_shared_memory.f
sv/dssm_pkg.sv
sv/dssm_dp.sv
sv/dssm_ctrl.sv
sv/dual_stack_shared_memory.sv
tb/dual_stack_shared_memory_test.sv
